// ===== rtl/dol_pkg.sv =====
`default_nettype none

package dol_pkg;

    // Sizing of the logger.
    localparam int CHANNELS      = 2;
    localparam int SESSION_SLOTS = 16;
    localparam int IDX_W         = 4;
    localparam int FILL_W        = 5;
    localparam int MS_W          = 32;
    localparam int SEC_W         = 32;
    localparam int DEBOUNCE_W    = 16;

    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd50;

    // Operation codes carried by an input item.
    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    // One input item.
    typedef struct packed {
        logic [1:0]          op;
        logic [CHANNELS-1:0] pin_levels;
        logic [MS_W-1:0]     now_ms;
        logic                clock_valid;
        logic [SEC_W-1:0]    wall_seconds;
        logic [IDX_W-1:0]    read_index;
    } dol_item_t;

    // One result item.
    typedef struct packed {
        logic [CHANNELS-1:0] stable_on;
        logic [CHANNELS-1:0] open_sessions;
        logic [FILL_W-1:0]   stored_count;
        logic [CHANNELS-1:0] recorded_now;
        logic [CHANNELS-1:0] dropped_now;
        logic                entry_valid;
        logic                entry_channel;
        logic [SEC_W-1:0]    entry_start;
        logic [SEC_W-1:0]    entry_end;
        logic [SEC_W-1:0]    entry_duration;
    } dol_result_t;

    // One stored session.
    typedef struct packed {
        logic             channel;
        logic [SEC_W-1:0] start;
        logic [SEC_W-1:0] stop;
    } dol_entry_t;

endpackage

`default_nettype wire

// ===== rtl/debounced_on_interval_logger_unit.sv =====
// Debounced on-interval logger.
//
// Input channel (in_valid, in_stall, in_item): each item is a pin sample,
// a read of one stored session, or a clear of the session store. An item
// is taken at a clock edge with in_valid high and in_stall low.
// Output channel (out_valid, out_stall, out_item): exactly one result item
// per input item, in order, showing the state after that item.
// Configuration (cfg_valid, cfg_ready, cfg_data): writes debounce_ms; the
// port is always ready and should be written only while the block is idle.
//
// An item's result is registered at the edge that takes it. Throughput is
// one item per cycle while no result is stalled; all per-channel
// debounce logic and the session append run in parallel between the input
// and the result register, and the 16-entry session store is a register
// file with one read and up to one write per channel each cycle.
// When the receiver stalls with a result waiting, in_stall rises and the
// held result stays unchanged until taken.
// Reset clears levels, sessions, the store fill count and the output valid
// and sets debounce_ms to 50; store contents are not cleared.
`default_nettype none

module debounced_on_interval_logger_unit (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire dol_pkg::dol_item_t                  in_item,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output dol_pkg::dol_result_t                     out_item,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [dol_pkg::DEBOUNCE_W-1:0]      cfg_data
);

    import dol_pkg::*;

    // State registers.
    logic [DEBOUNCE_W-1:0] debounce_reg;
    logic [CHANNELS-1:0]   level_reg, level_next;
    logic [CHANNELS-1:0]   settling_reg, settling_next;
    logic [MS_W-1:0]       seen_reg [CHANNELS];
    logic [MS_W-1:0]       seen_next [CHANNELS];
    logic [CHANNELS-1:0]   open_reg, open_next;
    logic [SEC_W-1:0]      start_reg [CHANNELS];
    logic [SEC_W-1:0]      start_next [CHANNELS];
    logic [FILL_W-1:0]     fill_reg, fill_next;
    dol_entry_t            store_reg [SESSION_SLOTS];

    logic                  out_valid_reg;
    dol_result_t           out_item_reg;
    dol_result_t           result;

    // Append requests, one per channel.
    logic [CHANNELS-1:0]   wr_en;
    logic [IDX_W-1:0]      wr_pos [CHANNELS];
    logic [CHANNELS-1:0]   rec;
    logic [CHANNELS-1:0]   drop;

    logic                  in_fire;
    logic [MS_W-1:0]       elapsed [CHANNELS];
    logic [FILL_W-1:0]     pos;
    logic                  raw;
    dol_entry_t            rd_entry;
    logic                  rd_hit;

    assign in_stall  = out_valid_reg && out_stall;
    assign in_fire   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // Time since the first differing sample, per channel.
    always_comb
    begin
        for (int ch = 0; ch < CHANNELS; ch++)
        begin
            elapsed[ch] = in_item.now_ms - seen_reg[ch];
        end
    end

    // Debounce, session open/close and append positions for one item.
    always_comb
    begin
        level_next    = level_reg;
        settling_next = settling_reg;
        open_next     = open_reg;
        fill_next     = fill_reg;
        wr_en         = '0;
        rec           = '0;
        drop          = '0;
        pos           = fill_reg;
        raw           = 1'b0;
        for (int ch = 0; ch < CHANNELS; ch++)
        begin
            seen_next[ch]  = seen_reg[ch];
            start_next[ch] = start_reg[ch];
            wr_pos[ch]     = pos[IDX_W-1:0];
        end

        if (in_item.op == OP_SAMPLE)
        begin
            for (int ch = 0; ch < CHANNELS; ch++)
            begin
                raw        = !in_item.pin_levels[ch];
                wr_pos[ch] = pos[IDX_W-1:0];
                if (raw == level_reg[ch])
                begin
                    settling_next[ch] = 1'b0;
                end
                else if (!settling_reg[ch])
                begin
                    seen_next[ch]     = in_item.now_ms;
                    settling_next[ch] = 1'b1;
                end
                else if (elapsed[ch] >= MS_W'(debounce_reg))
                begin
                    level_next[ch]    = raw;
                    settling_next[ch] = 1'b0;
                    if (raw)
                    begin
                        if (in_item.clock_valid)
                        begin
                            start_next[ch] = in_item.wall_seconds;
                            open_next[ch]  = 1'b1;
                        end
                    end
                    else if (open_reg[ch] && in_item.clock_valid)
                    begin
                        open_next[ch] = 1'b0;
                        if (pos < FILL_W'(SESSION_SLOTS))
                        begin
                            wr_en[ch] = 1'b1;
                            rec[ch]   = 1'b1;
                            pos       = pos + 1'b1;
                        end
                        else
                        begin
                            drop[ch] = 1'b1;
                        end
                    end
                end
            end
            fill_next = pos;
        end
        else if (in_item.op == OP_CLEAR)
        begin
            fill_next = '0;
        end
    end

    // Read of one stored session.
    assign rd_entry = store_reg[in_item.read_index];
    assign rd_hit   = (in_item.op == OP_READ) && (FILL_W'(in_item.read_index) < fill_reg);

    // Result item, taken after the update.
    always_comb
    begin
        result                = '0;
        result.stable_on      = level_next;
        result.open_sessions  = open_next;
        result.stored_count   = fill_next;
        result.recorded_now   = rec;
        result.dropped_now    = drop;
        if (rd_hit)
        begin
            result.entry_valid    = 1'b1;
            result.entry_channel  = rd_entry.channel;
            result.entry_start    = rd_entry.start;
            result.entry_end      = rd_entry.stop;
            result.entry_duration = rd_entry.stop - rd_entry.start;
        end
    end

    // Control and per-channel state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg  <= DEBOUNCE_RESET;
            level_reg     <= '0;
            settling_reg  <= '0;
            open_reg      <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int ch = 0; ch < CHANNELS; ch++)
            begin
                seen_reg[ch]  <= '0;
                start_reg[ch] <= '0;
            end
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                debounce_reg <= cfg_data;
            end
            if (in_fire)
            begin
                level_reg     <= level_next;
                settling_reg  <= settling_next;
                open_reg      <= open_next;
                fill_reg      <= fill_next;
                out_valid_reg <= 1'b1;
                for (int ch = 0; ch < CHANNELS; ch++)
                begin
                    seen_reg[ch]  <= seen_next[ch];
                    start_reg[ch] <= start_next[ch];
                end
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result register and session store.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            out_item_reg <= result;
            for (int ch = 0; ch < CHANNELS; ch++)
            begin
                if (wr_en[ch])
                begin
                    store_reg[wr_pos[ch]] <= '{channel: 1'(ch),
                                               start:   start_reg[ch],
                                               stop:    in_item.wall_seconds};
                end
            end
        end
    end

    // The fill count never passes the store depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(SESSION_SLOTS))
        else $error("session store fill count overflow");

    // A session is dropped only when the store is full.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_item.dropped_now != '0)
            |-> out_item.stored_count == FILL_W'(SESSION_SLOTS))
        else $error("session dropped with room left");

    // A sample grows the fill count by the sessions it recorded.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && (in_item.op == OP_SAMPLE)
            |=> out_item.stored_count
                == $past(fill_reg) + FILL_W'($countones(out_item.recorded_now)))
        else $error("fill count does not match recorded sessions");

    // Only samples record or drop sessions.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && (in_item.op != OP_SAMPLE)
            |=> (out_item.recorded_now == '0) && (out_item.dropped_now == '0))
        else $error("non-sample item reported a session");

    // A stalled result is held.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("held result changed under stall");

endmodule

`default_nettype wire

// ===== verif/interval_log_checker.sv =====
`timescale 1ns / 100ps

module interval_log_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  dol_pkg::dol_item_t             in_item,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  dol_pkg::dol_result_t           out_item,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [dol_pkg::DEBOUNCE_W-1:0] cfg_data,
    output int                             mismatch_count,
    output int                             results_owed
);

    import dol_pkg::*;

    // Shadow copy of the logger state.
    logic [DEBOUNCE_W-1:0] debounce;
    logic [CHANNELS-1:0]   level_on;
    logic [CHANNELS-1:0]   settling;
    logic [CHANNELS-1:0]   sess_open;
    logic [MS_W-1:0]       first_change_ms [CHANNELS];
    logic [SEC_W-1:0]      start_sec [CHANNELS];
    dol_entry_t            sessions [SESSION_SLOTS];
    int                    fill;

    // Status items predicted for accepted input items, oldest first.
    dol_result_t predicted_status [$];

    // Applies one input item to the shadow state and returns the status item it causes.
    function automatic dol_result_t logger_step(input dol_item_t it);
        dol_result_t     res;
        logic [MS_W-1:0] elapsed;
        logic            raw_on;
        res = '0;
        case (it.op)
            OP_SAMPLE:
            begin
                for (int ch = 0; ch < CHANNELS; ch++)
                begin
                    // A low pin level means the light is on.
                    raw_on  = ~it.pin_levels[ch];
                    elapsed = it.now_ms - first_change_ms[ch];
                    if (raw_on == level_on[ch])
                    begin
                        settling[ch] = 1'b0;
                    end
                    else if (!settling[ch])
                    begin
                        first_change_ms[ch] = it.now_ms;
                        settling[ch]        = 1'b1;
                    end
                    else if (elapsed >= debounce)
                    begin
                        level_on[ch] = raw_on;
                        settling[ch] = 1'b0;
                        if (raw_on)
                        begin
                            // A session opens only with a usable wall clock.
                            if (it.clock_valid)
                            begin
                                start_sec[ch] = it.wall_seconds;
                                sess_open[ch] = 1'b1;
                            end
                        end
                        else if (sess_open[ch] && it.clock_valid)
                        begin
                            sess_open[ch] = 1'b0;
                            if (fill < SESSION_SLOTS)
                            begin
                                sessions[fill] = '{channel: 1'(ch), start: start_sec[ch],
                                                   stop: it.wall_seconds};
                                fill++;
                                res.recorded_now[ch] = 1'b1;
                            end
                            else
                            begin
                                res.dropped_now[ch] = 1'b1;
                            end
                        end
                    end
                end
            end
            OP_READ:
            begin
                if (int'(it.read_index) < fill)
                begin
                    res.entry_valid    = 1'b1;
                    res.entry_channel  = sessions[it.read_index].channel;
                    res.entry_start    = sessions[it.read_index].start;
                    res.entry_end      = sessions[it.read_index].stop;
                    res.entry_duration = sessions[it.read_index].stop
                                         - sessions[it.read_index].start;
                end
            end
            OP_CLEAR:
            begin
                fill = 0;
            end
            default:
            begin
            end
        endcase
        res.stable_on     = level_on;
        res.open_sessions = sess_open;
        res.stored_count  = FILL_W'(fill);
        return res;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Outputs are checked before the input item of the same edge is predicted.
    always @(posedge clk)
    begin
        dol_result_t want;
        if (!rst_n)
        begin
            debounce       = DEBOUNCE_RESET;
            level_on       = '0;
            settling       = '0;
            sess_open      = '0;
            fill           = 0;
            mismatch_count = 0;
            for (int ch = 0; ch < CHANNELS; ch++)
            begin
                first_change_ms[ch] = '0;
                start_sec[ch]       = '0;
            end
            predicted_status.delete();
            results_owed <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                debounce = cfg_data;
            if (out_valid && !out_stall)
            begin
                if (predicted_status.size() == 0)
                begin
                    $display("%0t: status item with none expected, actual %h", $time, out_item);
                    mismatch_count++;
                end
                else
                begin
                    want = predicted_status.pop_front();
                    check_field("stable_on", want.stable_on, out_item.stable_on);
                    check_field("open_sessions", want.open_sessions, out_item.open_sessions);
                    check_field("stored_count", want.stored_count, out_item.stored_count);
                    check_field("recorded_now", want.recorded_now, out_item.recorded_now);
                    check_field("dropped_now", want.dropped_now, out_item.dropped_now);
                    check_field("entry_valid", want.entry_valid, out_item.entry_valid);
                    check_field("entry_channel", want.entry_channel, out_item.entry_channel);
                    check_field("entry_start", want.entry_start, out_item.entry_start);
                    check_field("entry_end", want.entry_end, out_item.entry_end);
                    check_field("entry_duration", want.entry_duration,
                                out_item.entry_duration);
                end
            end
            if (in_valid && !in_stall)
                predicted_status.push_back(logger_step(in_item));
            results_owed <= predicted_status.size();
        end
    end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import dol_pkg::*;

    // Operation code with no function; the block only reports status.
    localparam logic [1:0] OP_UNUSED      = 2'd3;
    localparam int         WATCHDOG_LIMIT = 1000;
    localparam int         PHASE_ITEMS    = 120;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    dol_item_t             in_item   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    dol_result_t           out_item;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [DEBOUNCE_W-1:0] cfg_data  = '0;
    int                    mismatch_count;
    int                    results_owed;

    // Stimulus state: idling switch, pin pattern being held, and time cursors.
    bit                    steady       = 1'b0;
    int                    stall_left   = 0;
    int                    quiet_cycles = 0;
    logic [CHANNELS-1:0]   pin_target   = '1;
    logic [MS_W-1:0]       ms_cursor    = '0;
    logic [SEC_W-1:0]      sec_cursor   = '0;
    logic [DEBOUNCE_W-1:0] debounce_now = DEBOUNCE_RESET;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    debounced_on_interval_logger_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    interval_log_checker log_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_item        (in_item),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_item       (out_item),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    // The receiver may stall for a random length after each status item, but not while steady is set.
    always @(posedge clk)
    begin
        int hold;
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (out_valid && !out_stall)
        begin
            hold = steady ? 0 : $urandom_range(0, 4);
            stall_left <= hold;
            out_stall  <= (hold != 0);
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_stall  <= (stall_left > 1);
        end
    end

    // Ends the run when no handshake completes for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles + 1 >= WATCHDOG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // An item of the given operation with every field random.
    function automatic dol_item_t misc_item(input logic [1:0] op);
        dol_item_t it;
        it.op           = op;
        it.pin_levels   = CHANNELS'($urandom_range(0, 3));
        it.now_ms       = $urandom;
        it.clock_valid  = 1'($urandom_range(0, 1));
        it.wall_seconds = $urandom;
        it.read_index   = IDX_W'($urandom_range(0, 15));
        return it;
    endfunction

    function automatic dol_item_t read_item(input logic [IDX_W-1:0] idx);
        dol_item_t it;
        it            = misc_item(OP_READ);
        it.read_index = idx;
        return it;
    endfunction

    function automatic dol_item_t sample_item(input logic [CHANNELS-1:0] pins,
                                              input logic [MS_W-1:0] now,
                                              input logic clock_ok,
                                              input logic [SEC_W-1:0] wall);
        dol_item_t it;
        it              = misc_item(OP_SAMPLE);
        it.pin_levels   = pins;
        it.now_ms       = now;
        it.clock_valid  = clock_ok;
        it.wall_seconds = wall;
        return it;
    endfunction

    // A pin sample that holds a pattern for a while, with time steps around the
    // debounce window, occasional glitches, and wraps of both clocks.
    function automatic dol_item_t next_sample();
        logic [CHANNELS-1:0] pins;
        int                  roll;
        if ($urandom_range(0, 99) < 15)
            pin_target = CHANNELS'($urandom_range(0, 3));
        pins = pin_target;
        if ($urandom_range(0, 99) < 12)
            pins[$urandom_range(0, CHANNELS - 1)] ^= 1'b1;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            ms_cursor = ms_cursor + $urandom_range(0, debounce_now / 2 + 1);
        else if (roll < 80)
            ms_cursor = ms_cursor + debounce_now + $urandom_range(0, 2) - 1;
        else if (roll < 90)
            ms_cursor = $urandom;
        if ($urandom_range(0, 99) < 5)
            sec_cursor = $urandom;
        else
            sec_cursor = sec_cursor + $urandom_range(0, 1000);
        return sample_item(pins, ms_cursor, $urandom_range(0, 9) != 0, sec_cursor);
    endfunction

    // Offers one item after a random gap (none while steady is set) and returns at the edge that takes it.
    task automatic send_item(input dol_item_t item);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 4);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= item;
        do @(posedge clk); while (in_stall);
    endtask

    // Holds off the sender until every status item has been delivered.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (results_owed != 0);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_debounce(input logic [DEBOUNCE_W-1:0] value);
        wait_for_results();
        debounce_now = value;
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input int count);
        int pick;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 80)
                send_item(next_sample());
            else if (pick < 92)
                send_item(misc_item(OP_READ));
            else if (pick < 94)
                send_item(misc_item(OP_CLEAR));
            else if (pick < 97)
                send_item(misc_item(OP_UNUSED));
            else
                send_item(misc_item(OP_SAMPLE));
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset debounce of 50 ms; the first window straddles the ms wrap.
        send_item(sample_item(2'b11, 32'hFFFF_FFC0, 1'b1, 32'd5));
        send_item(misc_item(OP_READ));
        send_item(misc_item(OP_UNUSED));
        send_item(sample_item(2'b00, 32'hFFFF_FFF0, 1'b1, 32'd1000));
        send_item(sample_item(2'b00, 32'h0000_001F, 1'b1, 32'd1001));
        send_item(sample_item(2'b00, 32'h0000_0022, 1'b1, 32'hFFFF_FFF0));
        // Channel 1 bounces back before its window ends, so timing is abandoned.
        send_item(sample_item(2'b10, 32'h0000_0030, 1'b1, 32'd0));
        send_item(sample_item(2'b00, 32'h0000_0040, 1'b1, 32'd0));
        // Channel 1 goes off without a clock and keeps its session open.
        send_item(sample_item(2'b10, 32'h0000_0100, 1'b1, 32'd6));
        send_item(sample_item(2'b10, 32'h0000_0133, 1'b0, 32'd7));
        // Channel 0 closes a session whose duration wraps around.
        send_item(sample_item(2'b11, 32'h0000_0200, 1'b1, 32'd8));
        send_item(sample_item(2'b11, 32'h0000_0232, 1'b1, 32'h0000_0010));
        send_item(read_item(4'd0));
        // Channel 0 turns on without a clock, then off with no session open.
        send_item(sample_item(2'b10, 32'h0000_0400, 1'b0, 32'd30));
        send_item(sample_item(2'b10, 32'h0000_0440, 1'b0, 32'd31));
        send_item(sample_item(2'b11, 32'h0000_0500, 1'b1, 32'd40));
        send_item(sample_item(2'b11, 32'h0000_0540, 1'b1, 32'hFFFF_FFFF));
        // Channel 1 turns on again with a clock, replacing its old start.
        send_item(sample_item(2'b01, 32'h0000_0600, 1'b1, 32'd50));
        send_item(sample_item(2'b01, 32'h0000_0640, 1'b1, 32'd60));
        send_item(sample_item(2'b11, 32'h0000_0700, 1'b1, 32'd80));
        send_item(sample_item(2'b11, 32'h0000_0740, 1'b1, 32'd90));
        send_item(read_item(4'd1));
        send_item(misc_item(OP_CLEAR));
        send_item(read_item(4'd0));

        // Zero debounce: fill the session store past its end so sessions drop.
        write_debounce(16'd0);
        for (int k = 0; k < 10; k++)
        begin
            for (int j = 0; j < 4; j++)
                send_item(sample_item((j < 2) ? 2'b00 : 2'b11, ms_cursor + j, 1'b1, $urandom));
            ms_cursor = ms_cursor + 4;
        end
        for (int k = 0; k < 4; k++)
            send_item(read_item(IDX_W'($urandom_range(0, SESSION_SLOTS - 1))));
        run_phase(PHASE_ITEMS);

        // One phase runs with no idling on either side.
        write_debounce(16'd1);
        steady = 1'b1;
        run_phase(PHASE_ITEMS);
        steady = 1'b0;

        write_debounce(16'hFFFF);
        run_phase(PHASE_ITEMS);
        write_debounce(DEBOUNCE_W'($urandom_range(2, 200)));
        run_phase(PHASE_ITEMS);
        write_debounce(DEBOUNCE_W'($urandom_range(0, 65535)));
        run_phase(PHASE_ITEMS);

        wait_for_results();
        if (mismatch_count == 0 && results_owed == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
